@@ rtl/core/tgad_pkg.sv @@
// Shared types and constants for the TGA pixel stream decoder.
package tgad_pkg;

    localparam int DIM_BITS = 16;

    localparam logic [7:0]  RUN_THRESH  = 8'd128;
    localparam logic [7:0]  RUN_BIAS    = 8'd127;
    localparam logic [15:0] MIN_WIDTH   = 16'd4;
    localparam logic [15:0] MIN_HEIGHT  = 16'd1;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_COMPRESSED = 3'd0;
    localparam logic [2:0] REG_ALPHA      = 3'd1;
    localparam logic [2:0] REG_WIDTH      = 3'd2;
    localparam logic [2:0] REG_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_FLIP       = 3'd4;

    // Byte position of the last byte of a pixel
    localparam logic [1:0] LAST_BYTE_BGR  = 2'd2;
    localparam logic [1:0] LAST_BYTE_BGRA = 2'd3;

    typedef struct packed {
        logic                compressed_mode;
        logic                alpha_present;
        logic [DIM_BITS-1:0] image_width;
        logic [DIM_BITS-1:0] image_height;
        logic                flip_rows;
    } tgad_cfg_t;

    typedef struct packed {
        logic byte_go;   // consume the input beat
        logic seg_load;  // load the next segment into the output register
    } tgad_cmd_t;

    typedef struct packed {
        logic pix_emit;  // the current byte completes a pixel that produces output
        logic seg_final; // the pending segment is the last one for this pixel
    } tgad_status_t;

    typedef enum logic [0:0] {
        ST_BYTE = 1'b0,
        ST_EMIT = 1'b1
    } tgad_state_t;

endpackage

@@ rtl/core/tgad_ctrl.sv @@
// Controller state machine: input acceptance, segment sequencing, output valid.
module tgad_ctrl
    import tgad_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  tgad_status_t sts,
    output tgad_cmd_t    cmd
);

    tgad_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        slot_free;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_BYTE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign slot_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.byte_go  = 1'b0;
        cmd.seg_load = 1'b0;
        unique case (state_reg)
            ST_BYTE: begin
                s_ready     = 1'b1;
                cmd.byte_go = s_valid;
                if (s_valid && sts.pix_emit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.seg_load = slot_free;
                if (slot_free && sts.seg_final) begin
                    state_next = ST_BYTE;
                end
            end
            default: begin
                state_next = ST_BYTE;
            end
        endcase
        m_valid_next = cmd.seg_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid = m_valid_reg;

endmodule

@@ rtl/core/tgad_dpath.sv @@
// Datapath: packet and pixel assembly, row/column tracking, segment output register.
module tgad_dpath
    import tgad_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  tgad_cfg_t           cfg,
    input  tgad_cmd_t           cmd,
    output tgad_status_t        sts,
    input  logic [7:0]          s_data_byte,
    output logic [7:0]          m_red,
    output logic [7:0]          m_green,
    output logic [7:0]          m_blue,
    output logic [7:0]          m_alpha,
    output logic [DIM_BITS-1:0] m_dest_row,
    output logic [DIM_BITS-1:0] m_start_col,
    output logic [7:0]          m_seg_length,
    output logic                m_last_of_run,
    output logic                m_image_done
);

    // Packet and position state
    logic                expect_header_reg, expect_header_next;
    logic                is_run_reg, is_run_next;
    logic [7:0]          pkt_left_reg, pkt_left_next;
    logic [1:0]          byte_idx_reg, byte_idx_next;
    logic [23:0]         pix_bytes_reg, pix_bytes_next;
    logic                clip_reg, clip_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [7:0]          count_reg, count_next;

    // Latched pixel of the pending segments
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;

    // Output payload registers
    logic [7:0]          o_red_reg, o_green_reg, o_blue_reg, o_alpha_reg;
    logic [DIM_BITS-1:0] o_row_reg, o_col_reg;
    logic [7:0]          o_len_reg;
    logic                o_last_reg, o_done_reg;

    // Byte step signals
    logic [1:0]  last_byte;
    logic        is_header, is_store, pix_emit;
    logic [7:0]  red_v, alpha_v, pix_count;

    // Segment signals
    logic [DIM_BITS-1:0] w_eff, h_eff;
    logic [DIM_BITS:0]   r0, r2, room, col_sum;
    logic [DIM_BITS-1:0] c0, r1, dest_row;
    logic [7:0]          seg, cnt_left;
    logic                end_row, done;

    // Decode the incoming byte
    always_comb begin
        expect_header_next = expect_header_reg;
        is_run_next        = is_run_reg;
        pkt_left_next      = pkt_left_reg;
        byte_idx_next      = byte_idx_reg;
        pix_bytes_next     = pix_bytes_reg;
        clip_next          = clip_reg;
        pix_count          = 8'd1;
        pix_emit           = 1'b0;
        last_byte          = cfg.alpha_present ? LAST_BYTE_BGRA : LAST_BYTE_BGR;
        is_header          = cfg.compressed_mode && expect_header_reg;
        is_store           = byte_idx_reg < last_byte;
        red_v              = cfg.alpha_present ? pix_bytes_reg[23:16] : s_data_byte;
        alpha_v            = cfg.alpha_present ? s_data_byte : 8'd0;
        if (is_header) begin
            // Start a new packet
            if (s_data_byte < RUN_THRESH) begin
                is_run_next   = 1'b0;
                pkt_left_next = s_data_byte + 8'd1;
            end else begin
                is_run_next   = 1'b1;
                pkt_left_next = s_data_byte - RUN_BIAS;
            end
            expect_header_next = 1'b0;
            byte_idx_next      = 2'd0;
            pix_bytes_next     = 24'd0;
        end else if (is_store) begin
            // Collect a color byte
            unique case (byte_idx_reg)
                2'd0:    pix_bytes_next = pix_bytes_reg | {16'd0, s_data_byte};
                2'd1:    pix_bytes_next = pix_bytes_reg | {8'd0, s_data_byte, 8'd0};
                2'd2:    pix_bytes_next = pix_bytes_reg | {s_data_byte, 16'd0};
                default: pix_bytes_next = pix_bytes_reg;
            endcase
            byte_idx_next = byte_idx_reg + 2'd1;
        end else begin
            // Complete a pixel
            byte_idx_next  = 2'd0;
            pix_bytes_next = 24'd0;
            if (!cfg.compressed_mode) begin
                clip_next = 1'b0;
                pix_emit  = 1'b1;
            end else if (is_run_reg) begin
                pix_count          = (pkt_left_reg != 8'd0) ? pkt_left_reg : 8'd1;
                pkt_left_next      = 8'd0;
                expect_header_next = 1'b1;
                pix_emit           = 1'b1;
            end else begin
                pkt_left_next = (pkt_left_reg != 8'd0) ? pkt_left_reg - 8'd1 : 8'd0;
                if (pkt_left_next == 8'd0) begin
                    expect_header_next = 1'b1;
                end
                // Drop pixels of a packet that overran the image
                if (clip_reg) begin
                    if (expect_header_next) begin
                        clip_next = 1'b0;
                    end
                end else begin
                    pix_emit = 1'b1;
                end
            end
        end
    end

    // Place the pending segment
    always_comb begin
        w_eff = (cfg.image_width < MIN_WIDTH) ? MIN_WIDTH : cfg.image_width;
        h_eff = (cfg.image_height < MIN_HEIGHT) ? MIN_HEIGHT : cfg.image_height;
        if (col_reg >= w_eff) begin
            c0 = '0;
            r0 = {1'b0, row_reg} + 1'b1;
        end else begin
            c0 = col_reg;
            r0 = {1'b0, row_reg};
        end
        r1       = (r0 >= {1'b0, h_eff}) ? '0 : r0[DIM_BITS-1:0];
        room     = {1'b0, w_eff} - {1'b0, c0};
        seg      = (room < {{(DIM_BITS-7){1'b0}}, count_reg}) ? room[7:0] : count_reg;
        col_sum  = {1'b0, c0} + {{(DIM_BITS-7){1'b0}}, seg};
        end_row  = col_sum >= {1'b0, w_eff};
        r2       = {1'b0, r1} + 1'b1;
        done     = end_row && (r2 >= {1'b0, h_eff});
        cnt_left = count_reg - seg;
        dest_row = cfg.flip_rows ? (h_eff - 1'b1 - r1) : r1;
        if (end_row) begin
            col_next = '0;
            row_next = done ? '0 : r2[DIM_BITS-1:0];
        end else begin
            col_next = col_sum[DIM_BITS-1:0];
            row_next = r1;
        end
        count_next = done ? 8'd0 : cnt_left;
    end

    assign sts.pix_emit  = pix_emit;
    assign sts.seg_final = (cnt_left == 8'd0) || done;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            is_run_reg        <= 1'b0;
            pkt_left_reg      <= 8'd0;
            byte_idx_reg      <= 2'd0;
            pix_bytes_reg     <= 24'd0;
            clip_reg          <= 1'b0;
            row_reg           <= '0;
            col_reg           <= '0;
            count_reg         <= 8'd0;
        end else if (cmd.byte_go) begin
            expect_header_reg <= expect_header_next;
            is_run_reg        <= is_run_next;
            pkt_left_reg      <= pkt_left_next;
            byte_idx_reg      <= byte_idx_next;
            pix_bytes_reg     <= pix_bytes_next;
            clip_reg          <= clip_next;
            if (pix_emit) begin
                count_reg <= pix_count;
            end
        end else if (cmd.seg_load) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            count_reg <= count_next;
            // Discard the rest of a raw packet once the image is full
            if (done && cfg.compressed_mode && !is_run_reg && !expect_header_reg) begin
                clip_reg <= 1'b1;
            end
        end
    end

    // Pixel latch and output payload
    always_ff @(posedge aclk) begin
        if (cmd.byte_go && pix_emit) begin
            red_reg   <= red_v;
            green_reg <= pix_bytes_reg[15:8];
            blue_reg  <= pix_bytes_reg[7:0];
            alpha_reg <= alpha_v;
        end
        if (cmd.seg_load) begin
            o_red_reg   <= red_reg;
            o_green_reg <= green_reg;
            o_blue_reg  <= blue_reg;
            o_alpha_reg <= alpha_reg;
            o_row_reg   <= dest_row;
            o_col_reg   <= c0;
            o_len_reg   <= seg;
            o_last_reg  <= sts.seg_final;
            o_done_reg  <= done;
        end
    end

    assign m_red         = o_red_reg;
    assign m_green       = o_green_reg;
    assign m_blue        = o_blue_reg;
    assign m_alpha       = o_alpha_reg;
    assign m_dest_row    = o_row_reg;
    assign m_start_col   = o_col_reg;
    assign m_seg_length  = o_len_reg;
    assign m_last_of_run = o_last_reg;
    assign m_image_done  = o_done_reg;

endmodule

@@ rtl/core/tga_pixel_stream_decoder.sv @@
// TGA pixel stream decoder top level: configuration registers, controller and datapath.
// A byte that completes no pixel is taken in ST_BYTE; one that completes a pixel moves the
// controller to ST_EMIT for its row segments (1 to 33), set by the single segment placement unit.
// ST_EMIT loads the first segment into the output registers once the output slot is free; segments follow
// one per cycle while m_ready is high. The next byte is taken while the last segment waits.
// Synchronous active-low reset restores the register defaults and awaits a packet header.
module tga_pixel_stream_decoder
    import tgad_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_red,
    output logic [7:0]          m_green,
    output logic [7:0]          m_blue,
    output logic [7:0]          m_alpha,
    output logic [DIM_BITS-1:0] m_dest_row,
    output logic [DIM_BITS-1:0] m_start_col,
    output logic [7:0]          m_seg_length,
    output logic                m_last_of_run,
    output logic                m_image_done
);

    tgad_cfg_t    cfg_reg;
    tgad_cmd_t    cmd;
    tgad_status_t sts;
    logic         wr_en;
    logic [2:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.compressed_mode <= 1'b0;
            cfg_reg.alpha_present   <= 1'b0;
            cfg_reg.image_width     <= DIM_BITS'(4);
            cfg_reg.image_height    <= DIM_BITS'(1);
            cfg_reg.flip_rows       <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COMPRESSED: cfg_reg.compressed_mode <= pwdata[0];
                REG_ALPHA:      cfg_reg.alpha_present   <= pwdata[0];
                REG_WIDTH:      cfg_reg.image_width     <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT:     cfg_reg.image_height    <= pwdata[DIM_BITS-1:0];
                REG_FLIP:       cfg_reg.flip_rows       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx)
            REG_COMPRESSED: prdata = {31'd0, cfg_reg.compressed_mode};
            REG_ALPHA:      prdata = {31'd0, cfg_reg.alpha_present};
            REG_WIDTH:      prdata = 32'(cfg_reg.image_width);
            REG_HEIGHT:     prdata = 32'(cfg_reg.image_height);
            REG_FLIP:       prdata = {31'd0, cfg_reg.flip_rows};
            default:        prdata = 32'd0;
        endcase
    end

    tgad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tgad_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .s_data_byte   (s_data_byte),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha),
        .m_dest_row    (m_dest_row),
        .m_start_col   (m_start_col),
        .m_seg_length  (m_seg_length),
        .m_last_of_run (m_last_of_run),
        .m_image_done  (m_image_done)
    );

endmodule

@@ rtl/core/tgad_checker.sv @@
// Port-level assertions for the TGA pixel stream decoder, bound to the top level.
module tgad_checker
    import tgad_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [DIM_BITS-1:0] m_start_col,
    input logic [7:0]          m_seg_length,
    input logic                m_last_of_run,
    input logic                m_image_done
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_start_col) && $stable(m_seg_length))
        else $error("output beat changed while stalled");

    // Segment length stays within one packet
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seg_length != 8'd0) && (m_seg_length <= 8'd128))
        else $error("segment length out of range");

    // The image-complete segment ends its pixel's run
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_done |-> m_last_of_run)
        else $error("image done without last of run");

    // Input stalls while segments of a run are still pending
    a_run_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("input accepted during a run");

endmodule

bind tga_pixel_stream_decoder tgad_checker u_tgad_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_start_col   (m_start_col),
    .m_seg_length  (m_seg_length),
    .m_last_of_run (m_last_of_run),
    .m_image_done  (m_image_done)
);

@@ bench/tb_tga_pixel_stream_decoder.sv @@
// Self-checking testbench for the TGA pixel stream decoder: byte driver, segment monitor, predictor.
module tb_tga_pixel_stream_decoder
    import tgad_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEGS = 33;

    typedef struct packed {
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [7:0]          alpha;
        logic [DIM_BITS-1:0] dest_row;
        logic [DIM_BITS-1:0] start_col;
        logic [7:0]          seg_length;
        logic                last_of_run;
        logic                image_done;
    } row_seg_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [7:0]          m_red;
    logic [7:0]          m_green;
    logic [7:0]          m_blue;
    logic [7:0]          m_alpha;
    logic [DIM_BITS-1:0] m_dest_row;
    logic [DIM_BITS-1:0] m_start_col;
    logic [7:0]          m_seg_length;
    logic                m_last_of_run;
    logic                m_image_done;

    tga_pixel_stream_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha),
        .m_dest_row    (m_dest_row),
        .m_start_col   (m_start_col),
        .m_seg_length  (m_seg_length),
        .m_last_of_run (m_last_of_run),
        .m_image_done  (m_image_done)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stream bytes waiting to be driven and segments waiting to be seen
    logic [7:0] byte_fifo[$];
    row_seg_t   pending_segs[$];

    int errors = 0;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int segs_checked = 0;
    int images_done = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Decoder state mirror, reset values
    tgad_cfg_t  cfg = '{compressed_mode: 1'b0, alpha_present: 1'b0, image_width: MIN_WIDTH,
                        image_height: MIN_HEIGHT, flip_rows: 1'b0};
    logic       hdr_wait = 1'b1;
    logic       run_pkt = 1'b0;
    logic [7:0] pix_left = '0;
    logic [1:0] byte_pos = '0;
    logic [23:0] pix_acc = '0;
    int         row = 0;
    int         col = 0;
    logic       discard_rest = 1'b0;

    // Advance the decoder mirror by one byte and queue the segments it yields
    function automatic void decode_byte(input logic [7:0] b);
        int need, cnt, w, h, seg, n;
        logic [7:0] red, green, blue, alpha;
        logic done;
        row_seg_t s;
        if (cfg.compressed_mode && hdr_wait) begin
            run_pkt = (b >= RUN_THRESH);
            pix_left = run_pkt ? b - RUN_BIAS : b + 8'd1;
            hdr_wait = 1'b0;
            byte_pos = '0;
            pix_acc = '0;
            return;
        end
        need = cfg.alpha_present ? 4 : 3;
        if (int'(byte_pos) + 1 < need) begin
            pix_acc = 24'({8'h00, pix_acc} | (32'(b) << (8 * byte_pos)));
            byte_pos = byte_pos + 2'd1;
            return;
        end
        // Pixel complete: bytes arrive as B, G, R (, A)
        blue = pix_acc[7:0];
        green = pix_acc[15:8];
        red = cfg.alpha_present ? pix_acc[23:16] : b;
        alpha = cfg.alpha_present ? b : 8'd0;
        byte_pos = '0;
        pix_acc = '0;
        if (!cfg.compressed_mode) begin
            cnt = 1;
            discard_rest = 1'b0;
        end else if (run_pkt) begin
            cnt = (pix_left != 0) ? int'(pix_left) : 1;
            pix_left = '0;
            hdr_wait = 1'b1;
        end else begin
            cnt = 1;
            if (pix_left != 0) pix_left = pix_left - 8'd1;
            if (pix_left == 0) hdr_wait = 1'b1;
            // Drop the tail of a raw packet that ran past the image
            if (discard_rest) begin
                if (hdr_wait) discard_rest = 1'b0;
                return;
            end
        end
        w = (cfg.image_width < MIN_WIDTH) ? int'(MIN_WIDTH) : int'(cfg.image_width);
        h = (cfg.image_height < MIN_HEIGHT) ? int'(MIN_HEIGHT) : int'(cfg.image_height);
        n = 0;
        // Split the pixel run at row ends
        while (cnt > 0 && n < MAX_SEGS) begin
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (row >= h) row = 0;
            done = 1'b0;
            seg = w - col;
            if (seg > cnt) seg = cnt;
            s.red = red;
            s.green = green;
            s.blue = blue;
            s.alpha = alpha;
            s.dest_row = cfg.flip_rows ? DIM_BITS'(h - 1 - row) : DIM_BITS'(row);
            s.start_col = DIM_BITS'(col);
            s.seg_length = 8'(seg);
            col += seg;
            cnt -= seg;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) begin
                    row = 0;
                    done = 1'b1;
                end
            end
            s.image_done = done;
            if (done) begin
                images_done++;
                if (cfg.compressed_mode && !run_pkt && !hdr_wait) discard_rest = 1'b1;
                cnt = 0;
            end
            n++;
            s.last_of_run = (cnt == 0 || n == MAX_SEGS);
            pending_segs.push_back(s);
        end
    endfunction

    // Byte driver: predict on each accepted beat, then offer the next byte or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data_byte <= '0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte);
                bytes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (byte_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data_byte <= byte_fifo.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Segment monitor: compare each beat with the oldest prediction, stall at random
    always @(posedge aclk) begin : seg_check
        row_seg_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_segs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected segment, expected none, actual row %0d col %0d len %0d",
                             $time, m_dest_row, m_start_col, m_seg_length);
                end else begin
                    want = pending_segs.pop_front();
                    check_field("red", 16'(want.red), 16'(m_red));
                    check_field("green", 16'(want.green), 16'(m_green));
                    check_field("blue", 16'(want.blue), 16'(m_blue));
                    check_field("alpha", 16'(want.alpha), 16'(m_alpha));
                    check_field("dest_row", 16'(want.dest_row), 16'(m_dest_row));
                    check_field("start_col", 16'(want.start_col), 16'(m_start_col));
                    check_field("seg_length", 16'(want.seg_length), 16'(m_seg_length));
                    check_field("last_of_run", 16'(want.last_of_run), 16'(m_last_of_run));
                    check_field("image_done", 16'(want.image_done), 16'(m_image_done));
                    segs_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Register write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COMPRESSED: cfg.compressed_mode = val[0];
            REG_ALPHA:      cfg.alpha_present = val[0];
            REG_WIDTH:      cfg.image_width = val[DIM_BITS-1:0];
            REG_HEIGHT:     cfg.image_height = val[DIM_BITS-1:0];
            REG_FLIP:       cfg.flip_rows = val[0];
            default: ;
        endcase
    endtask

    task automatic set_image(input logic comp, input logic alpha_on, input int w, input int h,
                             input logic flip);
        write_reg(REG_COMPRESSED, 32'(comp));
        write_reg(REG_ALPHA, 32'(alpha_on));
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
        write_reg(REG_FLIP, 32'(flip));
    endtask

    function automatic void push_byte(input logic [7:0] b);
        byte_fifo.push_back(b);
        bytes_queued++;
    endfunction

    // Queue one pixel as B, G, R (, A) for the current pixel size
    function automatic void push_pixel(input logic [31:0] bgra);
        push_byte(bgra[7:0]);
        push_byte(bgra[15:8]);
        push_byte(bgra[23:16]);
        if (cfg.alpha_present) push_byte(bgra[31:24]);
    endfunction

    // Mostly well-formed packets with random content, some stray bytes
    task automatic gen_random(input int n_items);
        int start, r, len;
        start = bytes_queued;
        while (bytes_queued - start < n_items) begin
            r = $urandom_range(99);
            if (!cfg.compressed_mode) begin
                if (r < 95) push_pixel($urandom());
                else push_byte(8'($urandom()));
            end else if (r < 40) begin
                len = ($urandom_range(49) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
                push_byte(8'(len - 1));
                repeat (len) push_pixel($urandom());
            end else if (r < 88) begin
                len = $urandom_range(1) ? $urandom_range(128, 1) : $urandom_range(8, 1);
                push_byte(8'(len + 127));
                push_pixel($urandom());
            end else begin
                repeat ($urandom_range(3, 1)) push_byte(8'($urandom()));
            end
        end
    endtask

    // Hold until every byte is taken and every segment seen, then let the pipe settle
    task automatic drain();
        while (byte_fifo.size() > 0 || s_valid || pending_segs.size() > 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, uncompressed 24-bit, black then white
        send_idle_pct = 24;
        recv_idle_pct = 73;
        push_pixel(32'h0000_0000);
        push_pixel(32'h00FF_FFFF);
        drain();

        // Directed: packet headers at their extremes, undersized dimensions, clipping
        write_reg(REG_COMPRESSED, 32'd1);
        write_reg(REG_WIDTH, 32'd2);
        write_reg(REG_HEIGHT, 32'd0);
        write_reg(REG_FLIP, 32'd1);
        push_byte(8'h00);
        push_pixel(32'h00FF_FFFF);
        push_byte(8'hFF);
        push_pixel(32'h0012_34AB);
        push_byte(8'h80);
        push_pixel(32'h0055_AA55);
        push_byte(8'h03);
        repeat (4) push_pixel($urandom());
        drain();

        // Random, sender 24% idle and receiver 73% idle
        set_image(1'b1, 1'b1, 4, 3, 1'b1);
        gen_random(95);
        drain();

        // Random, idle rates swapped
        send_idle_pct = 73;
        recv_idle_pct = 24;
        set_image(1'b0, 1'b0, 65535, 65535, 1'b0);
        gen_random(85);
        drain();
        set_image(1'b1, 1'b0, 5, 2, 1'b0);
        gen_random(85);
        drain();

        // Random, no idling; pause the sender once mid-phase
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_image(1'b1, 1'b1, 7, 65535, 1'b1);
        gen_random(40);
        drain();
        gen_random(40);
        drain();
        set_image(1'b1, 1'b0, 4, 1, 1'b0);
        gen_random(45);
        drain();

        $display("Covered %0d bytes, %0d segments checked, %0d images completed,",
                 bytes_accepted, segs_checked, images_done);
        $display("raw and run packets, 24/32-bit pixels, flipped rows, size changes mid-image.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tgad_pkg.sv
rtl/core/tgad_ctrl.sv
rtl/core/tgad_dpath.sv
rtl/core/tga_pixel_stream_decoder.sv
rtl/core/tgad_checker.sv
bench/tb_tga_pixel_stream_decoder.sv
